/* rtl/core/mpq_pkg.sv */
// Package for the multilevel priority queue: sizes, codes, RAM request type
// and address helper. No dependencies.
`default_nettype none

package mpq_pkg;

  localparam int LEVELS     = 5;
  localparam int RING_DEPTH = 16;

  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 2;

  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SLOT_W   = $clog2(RING_DEPTH);
  localparam int RAM_DEPTH = LEVELS * RING_DEPTH;
  localparam int ADDR_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic               we;
    addr_t              waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    addr_t              raddr;
  } ram_req_t;

  function automatic slot_t next_slot(input slot_t s);
    slot_t r;
    if (s == slot_t'(RING_DEPTH - 1)) r = '0;
    else r = s + slot_t'(1);
    return r;
  endfunction

  // Flat RAM address: level * RING_DEPTH + slot
  function automatic addr_t ring_addr(input lvl_t l, input slot_t s);
    addr_t r;
    r = addr_t'(l) * addr_t'(RING_DEPTH) + addr_t'(s);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mpq_if.sv */
// Request and response channel interfaces for the multilevel priority queue.
// Depends on mpq_pkg.
`default_nettype none

interface mpq_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [mpq_pkg::VALUE_W-1:0]    value;
  logic [mpq_pkg::LEVEL_W-1:0]    level;

  modport source (output valid, kind, value, level, input ready);
  modport sink   (input valid, kind, value, level, output ready);
  modport mon    (input valid, ready, kind, value, level);
endinterface

interface mpq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mpq_pkg::STATUS_W-1:0]   status;
  logic [mpq_pkg::VALUE_W-1:0]    data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
  modport mon    (input valid, ready, status, data);
endinterface

`default_nettype wire

/* rtl/core/mpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 80
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mpq_ctrl.sv */
// Ring bookkeeping: head, tail and empty mark per level, insert/remove
// decision and RAM request. Depends on mpq_pkg.
`default_nettype none

module mpq_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic                         kind,
  input  wire logic [mpq_pkg::VALUE_W-1:0]  value,
  input  wire logic [mpq_pkg::LEVEL_W-1:0]  level,
  output      mpq_pkg::status_t             status,
  output      mpq_pkg::ram_req_t            ram
);
  import mpq_pkg::*;

  slot_t head [LEVELS];
  slot_t tail [LEVELS];
  logic  empty [LEVELS];

  logic  lvl_ok;
  lvl_t  ins_lvl;
  slot_t ins_slot;
  logic  ins_go;
  logic  rm_found;
  lvl_t  rm_lvl;
  logic  rm_go;

  always_comb begin
    lvl_ok   = 32'(level) < LEVELS;
    ins_lvl  = lvl_t'(level);
    ins_slot = '0;
    ins_go   = 1'b0;
    rm_found = 1'b0;
    rm_lvl   = '0;
    rm_go    = 1'b0;
    status   = ST_OVERFLOW;

    // lowest-numbered non-empty level
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (!empty[i]) begin
        rm_found = 1'b1;
        rm_lvl   = lvl_t'(i);
      end
    end

    if (kind == KIND_REMOVE) begin
      rm_go  = rm_found;
      status = rm_found ? ST_REMOVED : ST_UNDERFLOW;
    end else if (lvl_ok) begin
      if (empty[ins_lvl]) begin
        ins_go = 1'b1;
        status = ST_INSERTED;
      end else if (next_slot(tail[ins_lvl]) != head[ins_lvl]) begin
        ins_slot = next_slot(tail[ins_lvl]);
        ins_go   = 1'b1;
        status   = ST_INSERTED;
      end
    end

    ram.we    = fire && ins_go;
    ram.waddr = ring_addr(ins_lvl, ins_slot);
    ram.wdata = value;
    ram.re    = fire && rm_go;
    ram.raddr = ring_addr(rm_lvl, head[rm_lvl]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        empty[i] <= 1'b1;
      end
    end else if (fire) begin
      if (ins_go) begin
        if (empty[ins_lvl]) begin
          head[ins_lvl]  <= '0;
          empty[ins_lvl] <= 1'b0;
        end
        tail[ins_lvl] <= ins_slot;
      end
      if (rm_go) begin
        if (head[rm_lvl] == tail[rm_lvl]) begin
          // last value leaves: ring back to its reset shape
          empty[rm_lvl] <= 1'b1;
          head[rm_lvl]  <= '0;
          tail[rm_lvl]  <= '0;
        end else begin
          head[rm_lvl] <= next_slot(head[rm_lvl]);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/multilevel_priority_queue.sv */
// Multilevel priority queue: one circular buffer per level in a shared RAM.
// Top level. Depends on mpq_pkg, mpq_if, mpq_ram, mpq_ctrl.
//
// Usage:
//   req channel carries kind (insert/remove), value and level. Each transfer
//   on req gives exactly one transfer on rsp with status and data.
//   Insert appends value to the ring of its level (overflow if the ring is
//   full or the level is out of range). Remove returns the oldest value of
//   the lowest-numbered non-empty level, or underflow.
//   Order: ring state updates and the RAM read issue at the req edge, the
//   item then sits in stage s1, and the RAM read data lands in the response
//   register when that register can move, which drives rsp.valid.
//   Throughput: one item per cycle while rsp.ready is high; bookkeeping sits
//   in flops and the ring RAM has one write and one read port.
//   Reset: all rings empty, no response pending. RAM contents are not
//   cleared; they are only read after being written.
//   Stall: when rsp.ready is low the response register holds, one more
//   item can sit in the middle stage, then req.ready drops.
`default_nettype none

module multilevel_priority_queue (
  input wire logic   clk,
  input wire logic   rst,
  mpq_req_if.sink    req,
  mpq_rsp_if.source  rsp
);
  import mpq_pkg::*;

  status_t            cur_status;
  ram_req_t           ram;
  logic [VALUE_W-1:0] rdata;

  logic               fire;
  logic               move;
  logic               s1_valid;
  status_t            s1_status;
  logic               out_valid;
  status_t            out_status;
  logic [VALUE_W-1:0] out_data;

  assign move      = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || move;
  assign fire      = req.valid && req.ready;

  mpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .kind   (req.kind),
    .value  (req.value),
    .level  (req.level),
    .status (cur_status),
    .ram    (ram)
  );

  mpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_status <= cur_status;
    end
    // rdata holds while s1 is stalled since no new read is issued
    if (move && s1_valid) begin
      out_status <= s1_status;
      out_data   <= (s1_status == ST_REMOVED) ? rdata : '0;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;

endmodule

`default_nettype wire

/* rtl/core/mpq_checker.sv */
// Port-level checks for the multilevel priority queue, bound to the top level.
// Depends on mpq_pkg and multilevel_priority_queue.
`default_nettype none

module mpq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [mpq_pkg::STATUS_W-1:0]  rsp_status,
  input wire logic [mpq_pkg::VALUE_W-1:0]   rsp_data
);
  import mpq_pkg::*;

  logic       acc_in;
  logic       acc_out;
  logic [2:0] pending;

  assign acc_in  = req_valid && req_ready;
  assign acc_out = rsp_valid && rsp_ready;

  // items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(acc_in) - 3'(acc_out);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data))
    else $error("response changed while stalled");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_REMOVED |-> rsp_data == '0)
    else $error("data nonzero without a removal");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_pending: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2 && (!acc_out || (pending != 3'd0)))
    else $error("response count does not match accepted requests");

endmodule

bind multilevel_priority_queue mpq_checker u_mpq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_data   (rsp.data)
);

`default_nettype wire

/* tb/multilevel_priority_queue_tb.sv */
// Self-checking testbench for multilevel_priority_queue: a directed table,
// then random insert/remove traffic checked against an in-bench predictor.
// Depends on mpq_pkg, mpq_if and the RTL of the queue.
`default_nettype none

module multilevel_priority_queue_tb;
  import mpq_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] data;
  } outcome_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0] level;
    logic               fixed;   // expectation typed in below
    status_t            status;
    logic [VALUE_W-1:0] data;
  } vector_t;

  localparam int QUIET_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;

  localparam vector_t DIRECTED [20] = '{
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 3'd7, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
    '{KIND_INSERT, 32'h1234_5678, 3'd5, 1'b1, ST_OVERFLOW,  32'h0000_0000},
    '{KIND_INSERT, 32'hFFFF_FFFF, 3'd7, 1'b1, ST_OVERFLOW,  32'h0000_0000},
    '{KIND_INSERT, 32'h8000_0000, 3'd4, 1'b1, ST_INSERTED,  32'h0000_0000},
    '{KIND_INSERT, 32'h7FFF_FFFF, 3'd0, 1'b1, ST_INSERTED,  32'h0000_0000},
    '{KIND_INSERT, 32'hFFFF_FFFF, 3'd2, 1'b1, ST_INSERTED,  32'h0000_0000},
    '{KIND_INSERT, 32'h0000_0000, 3'd4, 1'b1, ST_INSERTED,  32'h0000_0000},
    '{KIND_INSERT, 32'h0000_0001, 3'd0, 1'b1, ST_INSERTED,  32'h0000_0000},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b1, ST_REMOVED,   32'h7FFF_FFFF},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 3'd6, 1'b1, ST_REMOVED,   32'h0000_0001},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b1, ST_REMOVED,   32'hFFFF_FFFF},
    '{KIND_INSERT, 32'h5555_5555, 3'd3, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_INSERT, 32'hAAAA_AAAA, 3'd1, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_INSERT, 32'h0F0F_F0F0, 3'd6, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b0, ST_INSERTED,  32'h0000_0000},
    '{KIND_REMOVE, 32'h0000_0000, 3'd0, 1'b1, ST_UNDERFLOW, 32'h0000_0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpq_req_if req_ch ();
  mpq_rsp_if rsp_ch ();

  multilevel_priority_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // Predicted queue contents
  logic [VALUE_W-1:0] ring_words [LEVELS][RING_DEPTH];
  int                 head_slot  [LEVELS];
  int                 tail_slot  [LEVELS];
  bit                 ring_vacant[LEVELS];

  outcome_t           due_results[$];
  outcome_t           served, oldest;
  int                 mismatches   = 0;
  int                 quiet_cycles = 0;
  bit                 steady       = 1'b0;

  // Typed-in expectation travels with the request it belongs to
  logic               row_fixed;
  status_t            row_status;
  logic [VALUE_W-1:0] row_data;

  function automatic outcome_t serve_request(input logic kind,
                                             input logic [VALUE_W-1:0] value,
                                             input logic [LEVEL_W-1:0] level);
    outcome_t r;
    int       lv;
    bit       taken;
    r.status = ST_UNDERFLOW;
    r.data   = '0;
    lv       = int'(level);
    taken    = 1'b0;
    if (kind == KIND_INSERT) begin
      if (lv >= LEVELS) begin
        r.status = ST_OVERFLOW;
      end else if (ring_vacant[lv]) begin
        head_slot[lv]     = 0;
        tail_slot[lv]     = 0;
        ring_vacant[lv]   = 1'b0;
        ring_words[lv][0] = value;
        r.status          = ST_INSERTED;
      end else if ((tail_slot[lv] + 1) % RING_DEPTH == head_slot[lv]) begin
        r.status = ST_OVERFLOW;
      end else begin
        tail_slot[lv]                 = (tail_slot[lv] + 1) % RING_DEPTH;
        ring_words[lv][tail_slot[lv]] = value;
        r.status                      = ST_INSERTED;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        if (!taken && !ring_vacant[i]) begin
          taken    = 1'b1;
          r.status = ST_REMOVED;
          r.data   = ring_words[i][head_slot[i]];
          if (head_slot[i] == tail_slot[i]) begin
            ring_vacant[i] = 1'b1;
            head_slot[i]   = 0;
            tail_slot[i]   = 0;
          end else begin
            head_slot[i] = (head_slot[i] + 1) % RING_DEPTH;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Checker: compare responses first, then predict the new request
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_slot[i]   = 0;
        tail_slot[i]   = 0;
        ring_vacant[i] = 1'b1;
      end
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response: expected none, actual status %0d data %h",
                   $time, rsp_ch.status, rsp_ch.data);
        end else begin
          oldest = due_results.pop_front();
          if (rsp_ch.status !== oldest.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, oldest.status, rsp_ch.status);
          end
          if (rsp_ch.data !== oldest.data) begin
            mismatches++;
            $display("%0t: data mismatch: expected %h, actual %h",
                     $time, oldest.data, rsp_ch.data);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        served = serve_request(req_ch.kind, req_ch.value, req_ch.level);
        if (row_fixed) begin
          served.status = row_status;
          served.data   = row_data;
        end
        due_results.push_back(served);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("multilevel_priority_queue_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: random stalls before each transfer, none in steady phases
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic send(input logic kind, input logic [VALUE_W-1:0] value,
                      input logic [LEVEL_W-1:0] level, input logic fixed,
                      input status_t status, input logic [VALUE_W-1:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    req_ch.level <= level;
    row_fixed    <= fixed;
    row_status   <= status;
    row_data     <= data;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Lower valid and hold off until every response has come back
  task automatic drain_queue();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int   insert_pct;
    int   hot;
    int   pick;
    logic kind;
    logic [LEVEL_W-1:0] level;

    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_INSERT;
    req_ch.value <= '0;
    req_ch.level <= '0;
    row_fixed    <= 1'b0;
    row_status   <= ST_INSERTED;
    row_data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send(DIRECTED[i].kind, DIRECTED[i].value, DIRECTED[i].level,
           DIRECTED[i].fixed, DIRECTED[i].status, DIRECTED[i].data);
    drain_queue();

    // Phases rotate fill-heavy, mixed and drain-heavy traffic so that rings
    // hit overflow, wrap around and run dry
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      hot    = $urandom_range(0, LEVELS - 1);
      steady = (p % 4 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = ($urandom_range(1, 100) <= insert_pct) ? KIND_INSERT : KIND_REMOVE;
        pick = $urandom_range(0, 19);
        if (pick < 12)      level = LEVEL_W'(hot);
        else if (pick < 19) level = LEVEL_W'($urandom_range(0, LEVELS - 1));
        else                level = LEVEL_W'($urandom_range(LEVELS, 7));
        send(kind, $urandom, level, 1'b0, ST_INSERTED, '0);
      end
      if (p % 3 == 2) begin
        steady = 1'b0;
        drain_queue();
      end
    end

    steady = 1'b0;
    drain_queue();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("multilevel_priority_queue_tb passed");
    end else begin
      $display("multilevel_priority_queue_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
